/* src/sol_pkg.sv */
// shared constants, codes and types of the self-organizing list
package sol_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int CNT_W    = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] POL_FRONT     = 2'd0;
    localparam logic [1:0] POL_TRANSPOSE = 2'd1;
    localparam logic [1:0] POL_COUNT     = 2'd2;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]    count;
    } t_entry;

endpackage

/* src/sol_if.sv */
// command and result channel interfaces
interface sol_in_if import sol_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] key;

    modport source (output valid, command, key, input ready);
    modport sink   (input valid, command, key, output ready);
endinterface

interface sol_out_if import sol_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [4:0]       position;
    logic [CNT_W-1:0] hit_count;
    logic [5:0]       entries_used;

    modport source (output valid, status, position, hit_count, entries_used, input ready);
    modport sink   (input valid, status, position, hit_count, entries_used, output ready);
endinterface

/* src/self_organizing_list_top.sv */
// self-organizing list top level: one entry memory and the sequencer around it
//
// Bounded list of keys with access counts, held in list order in one
// simple dual-port memory (one write, one registered read per cycle).
// Commands are taken one at a time; in.ready is high only while the
// sequencer is idle, and a result waits in the output register without
// holding up the next command. Insert goes from idle straight to the
// done state and on to the result register. Search and delete scan
// from the head one entry per cycle through the memory read port. A hit
// then reorders by moving entries one slot per cycle through the same
// port, where delete moves the entry to the tail and drops it; an entry
// that stays in place skips the moves. Count order adds a second scan of
// the counts. No clearing pass after reset: only slots below the fill
// level are ever read.
module self_organizing_list_top import sol_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sol_in_if.sink           i_in,
    sol_out_if.source        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_policy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PLAN  = 3'd2;
    localparam logic [2:0] S_CSCAN = 3'd3;
    localparam logic [2:0] S_MSET  = 3'd4;
    localparam logic [2:0] S_MOVE  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // entry memory
    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    // control state
    logic [2:0]        r_state;
    logic [FILL_W-1:0] r_fill;
    logic [1:0]        r_policy;
    logic              r_pend;
    logic              r_more;
    logic              r_up;
    logic              r_out_valid;

    // working payload
    logic [1:0]          r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [FILL_W-1:0]   r_idx;
    logic [IDX_W-1:0]    r_cidx;
    logic [IDX_W-1:0]    r_pos;
    logic [IDX_W-1:0]    r_to;
    logic [IDX_W-1:0]    r_src;
    logic [IDX_W-1:0]    r_dst;
    logic [CNT_W-1:0]    r_cnt;
    logic [1:0]          r_status;

    // result register
    logic [1:0]       r_o_status;
    logic [4:0]       r_o_position;
    logic [CNT_W-1:0] r_o_hit_count;
    logic [5:0]       r_o_entries;

    logic             in_beat;
    logic             out_free;
    logic             issue;
    logic [IDX_W-1:0] last_idx;
    logic             key_hit;
    logic             cnt_hit;
    logic [CNT_W-1:0] cnt_inc;

    assign in_beat  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign issue    = r_idx < r_fill;
    assign last_idx = IDX_W'(r_fill - FILL_W'(1));
    assign key_hit  = r_pend && (r_rdata.key == r_key);
    assign cnt_hit  = r_pend && (r_cidx != r_pos) && (r_rdata.count <= r_cnt);
    // saturating count step
    assign cnt_inc  = (r_rdata.count == '1) ? r_rdata.count : r_rdata.count + CNT_W'(1);

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_o_status;
    assign o_out.position     = r_o_position;
    assign o_out.hit_count    = r_o_hit_count;
    assign o_out.entries_used = r_o_entries;

    // memory port steering: scans and moves read, insert / shift / final place write
    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_dst;
        wr_data = r_rdata;
        unique case (r_state) inside
            S_SCAN, S_CSCAN: begin
                rd_addr = r_idx[IDX_W-1:0];
            end
            S_MOVE: begin
                rd_addr = r_src;
                wr_en   = r_pend;
            end
            S_FIN: begin
                wr_en   = 1'b1;
                wr_addr = r_to;
                wr_data = '{key: r_key, count: r_cnt};
            end
            S_IDLE: begin
                wr_en   = in_beat && (i_in.command == CMD_INSERT) && (r_fill < FILL_W'(CAPACITY));
                wr_addr = r_fill[IDX_W-1:0];
                wr_data = '{key: i_in.key[KEY_BITS-1:0], count: '0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_policy    <= POL_FRONT;
            r_pend      <= 1'b0;
            r_more      <= 1'b0;
            r_up        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_policy <= i_cfg_policy;
            end
            // result beat loads when the register is free, clears when taken
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_cmd    <= i_in.command;
                        r_key    <= i_in.key[KEY_BITS-1:0];
                        r_cnt    <= '0;
                        r_idx    <= '0;
                        r_pend   <= 1'b0;
                        case (i_in.command) inside
                            CMD_INSERT: begin
                                r_state <= S_DONE;
                                if (r_fill >= FILL_W'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                    r_pos    <= '0;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_pos    <= r_fill[IDX_W-1:0];
                                    r_fill   <= r_fill + FILL_W'(1);
                                end
                            end
                            CMD_SEARCH, CMD_DELETE: begin
                                r_pos <= '0;
                                if (r_fill == '0) begin
                                    r_status <= ST_NOTFOUND;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_state  <= S_SCAN;
                                end
                            end
                            default: begin
                                r_status <= ST_DONE;
                                r_pos    <= '0;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end

                // pipelined key scan from the head
                S_SCAN: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_idx  <= r_idx + FILL_W'(1);
                        r_cidx <= r_idx[IDX_W-1:0];
                    end
                    if (key_hit) begin
                        r_pos   <= r_cidx;
                        r_cnt   <= cnt_inc;
                        r_state <= S_PLAN;
                    end else if (r_pend && r_cidx == last_idx) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_DONE;
                    end
                end

                // pick the destination slot, or start the count scan under count order
                S_PLAN: begin
                    if (r_cmd == CMD_DELETE) begin
                        r_to    <= last_idx;
                        r_state <= S_MSET;
                    end else if (r_policy == POL_COUNT) begin
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_CSCAN;
                    end else begin
                        r_state <= S_MSET;
                        case (r_policy)
                            POL_FRONT:     r_to <= '0;
                            POL_TRANSPOSE: r_to <= (r_pos == '0) ? r_pos : r_pos - IDX_W'(1);
                            default:       r_to <= r_pos;
                        endcase
                    end
                end

                // first other entry whose count is not greater
                S_CSCAN: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_idx  <= r_idx + FILL_W'(1);
                        r_cidx <= r_idx[IDX_W-1:0];
                    end
                    if (cnt_hit) begin
                        r_to    <= (r_cidx < r_pos) ? r_cidx : r_cidx - IDX_W'(1);
                        r_state <= S_MSET;
                    end else if (r_pend && r_cidx == last_idx) begin
                        r_to    <= last_idx;
                        r_state <= S_MSET;
                    end
                end

                S_MSET: begin
                    r_pend <= 1'b0;
                    r_more <= 1'b1;
                    r_up   <= (r_to < r_pos);
                    r_src  <= (r_to < r_pos) ? r_pos - IDX_W'(1) : r_pos + IDX_W'(1);
                    r_state <= (r_to == r_pos) ? S_FIN : S_MOVE;
                end

                // shift the entries between source and destination by one slot
                S_MOVE: begin
                    r_pend <= r_more;
                    if (r_more) begin
                        r_dst <= r_up ? r_src + IDX_W'(1) : r_src - IDX_W'(1);
                        if (r_src == r_to) begin
                            r_more <= 1'b0;
                        end else begin
                            r_src <= r_up ? r_src - IDX_W'(1) : r_src + IDX_W'(1);
                        end
                    end else if (r_pend) begin
                        r_state <= S_FIN;
                    end
                end

                // drop the moved entry in place; delete frees the tail
                S_FIN: begin
                    if (r_cmd == CMD_DELETE) begin
                        r_fill <= r_fill - FILL_W'(1);
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (out_free) begin
                        r_o_status    <= r_status;
                        r_o_position  <= 5'(r_pos);
                        r_o_hit_count <= r_cnt;
                        r_o_entries   <= 6'(r_fill);
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // fill level never passes the capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(CAPACITY))
        else $error("fill level above capacity");

    // a finished command reaches the result register once it is free
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded");

    // a delete hit frees exactly one entry
    a_delete_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_cmd == CMD_DELETE) |=> (r_fill == $past(r_fill) - FILL_W'(1)))
        else $error("delete did not shrink the list");

    // shift writes stay inside the used part of the list
    a_move_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE && r_pend) |-> (FILL_W'(r_dst) < r_fill))
        else $error("shift write outside the list");

endmodule
